### src/lmsd_pkg.sv
// Shared types, sizes and helpers for the LED matrix scan driver.
// No dependencies; every other file takes names from here, by scope or by import.
`timescale 1ns / 1ps
`default_nettype none
package lmsd_pkg;

  localparam int PANEL_WIDTH = 128;
  localparam int ROW_PAIRS   = 16;
  localparam int SUBFRAMES   = 8;

  localparam int COL_W    = $clog2(PANEL_WIDTH);
  localparam int RP_W     = $clog2(ROW_PAIRS);
  localparam int SF_W     = $clog2(SUBFRAMES);
  localparam int STORE_AW = RP_W + COL_W;
  localparam int STORE_DEPTH = 2 ** STORE_AW;

  localparam int LEVEL_W = 3;
  localparam int PIXEL_W = 3 * LEVEL_W;

  // Fold of the lower view half onto the panel
  localparam int FOLD_ROW   = 32;
  localparam int FOLD_ROW_M = 63;
  localparam int FOLD_COL_M = 127;
  localparam int POS_W      = 9;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_SCAN  = 2'd2;

  typedef logic [STORE_AW-1:0] addr_t;
  typedef logic [PIXEL_W-1:0]  pixel_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [RP_W-1:0]  rp;
    logic [SF_W-1:0]  sf;
    logic             last_col;
    logic             frame_end;
  } scan_pos_t;

  function automatic logic lit(input logic [LEVEL_W-1:0] level,
                               input logic [SF_W-1:0] k);
    logic [LEVEL_W-1:0] kx;
    kx = LEVEL_W'(k);
    return (level != '0) && (kx <= level);
  endfunction

endpackage
`default_nettype wire

### src/lmsd_ram.sv
// One half of the pixel store: single write port, registered read port.
// Depends on lmsd_pkg for address and pixel types.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_ram (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire lmsd_pkg::addr_t  wr_addr,
  input  wire lmsd_pkg::pixel_t wr_data,
  input  wire logic            rd_en,
  input  wire lmsd_pkg::addr_t  rd_addr,
  output lmsd_pkg::pixel_t      rd_data
);

  lmsd_pkg::pixel_t mem [lmsd_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### src/lmsd_scan_seq.sv
// Scan position sequencer: column, row pair and subframe counters.
// Depends on lmsd_pkg for sizes and the scan position struct.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_scan_seq (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  output lmsd_pkg::scan_pos_t pos
);

  logic [lmsd_pkg::COL_W-1:0] col;
  logic [lmsd_pkg::RP_W-1:0]  rp;
  logic [lmsd_pkg::SF_W-1:0]  sf;
  logic last_col, last_rp, last_sf;

  assign last_col = (col == lmsd_pkg::COL_W'(lmsd_pkg::PANEL_WIDTH - 1));
  assign last_rp  = (rp == lmsd_pkg::RP_W'(lmsd_pkg::ROW_PAIRS - 1));
  assign last_sf  = (sf == lmsd_pkg::SF_W'(lmsd_pkg::SUBFRAMES - 1));

  assign pos.col       = col;
  assign pos.rp        = rp;
  assign pos.sf        = sf;
  assign pos.last_col  = last_col;
  assign pos.frame_end = last_col && last_rp && last_sf;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      rp  <= '0;
      sf  <= '0;
    end else if (advance) begin
      if (last_col) begin
        col <= '0;
        if (last_rp) begin
          rp <= '0;
          sf <= last_sf ? '0 : sf + 1'b1;
        end else begin
          rp <= rp + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/lmsd_out_stage.sv
// Read-return stage and output register: turns stored levels into panel bits.
// Depends on lmsd_pkg for the lit helper and the scan position struct.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_out_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            issue,
  input  wire lmsd_pkg::scan_pos_t issue_pos,
  input  wire lmsd_pkg::pixel_t top_pixel,
  input  wire lmsd_pkg::pixel_t bottom_pixel,
  output logic                 hold,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 top_red,
  output logic                 top_green,
  output logic                 top_blue,
  output logic                 bottom_red,
  output logic                 bottom_green,
  output logic                 bottom_blue,
  output logic                 latch_row,
  output logic [3:0]           row_address,
  output logic [2:0]           subframe,
  output logic                 frame_end
);

  localparam int LW = lmsd_pkg::LEVEL_W;

  logic                s1_valid;
  lmsd_pkg::scan_pos_t s1_pos;
  logic                out_free;

  assign out_free = !out_valid || !out_stall;
  assign hold     = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= issue || (s1_valid && !out_free);
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
    if (issue) begin
      s1_pos <= issue_pos;
    end
    if (out_free && s1_valid) begin
      top_red      <= lmsd_pkg::lit(top_pixel[LW-1:0], s1_pos.sf);
      top_green    <= lmsd_pkg::lit(top_pixel[2*LW-1:LW], s1_pos.sf);
      top_blue     <= lmsd_pkg::lit(top_pixel[3*LW-1:2*LW], s1_pos.sf);
      bottom_red   <= lmsd_pkg::lit(bottom_pixel[LW-1:0], s1_pos.sf);
      bottom_green <= lmsd_pkg::lit(bottom_pixel[2*LW-1:LW], s1_pos.sf);
      bottom_blue  <= lmsd_pkg::lit(bottom_pixel[3*LW-1:2*LW], s1_pos.sf);
      latch_row    <= s1_pos.last_col;
      row_address  <= 4'(s1_pos.rp);
      subframe     <= 3'(s1_pos.sf);
      frame_end    <= s1_pos.frame_end;
    end
  end

endmodule
`default_nettype wire

### src/led_matrix_scan_driver.sv
// Top level of the LED matrix scan driver: input decode, fold, store clearing.
// Depends on lmsd_pkg, lmsd_ram, lmsd_scan_seq and lmsd_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   write pixel, clear store or scan tick. Writes take a 64x64 view position;
//   the lower view half is folded onto the far columns of the panel.
//   Output channel (out_valid / out_stall) carries one panel shift per scan
//   tick: six data bits, latch_row on the last column, row pair, subframe
//   and frame_end on the last shift of a frame. Writes and clears give none.
//   A scan tick's pixels go through the read stage to the output register.
//   Throughput: one transaction per cycle while in_stall is low, set by the
//   single read port of each store half (upper and lower rows read at once).
//   Reset and every clear run a clearing pass over all 2048 entries, one
//   entry of each half per cycle; in_stall is high throughout.
//   A stalled output holds its shift; one more scan tick may sit in the read
//   stage, after which in_stall rises until the output drains.
`timescale 1ns / 1ps
`default_nettype none
module led_matrix_scan_driver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [5:0] row_in,
  input  wire logic [5:0] column_in,
  input  wire logic [2:0] red_level,
  input  wire logic [2:0] green_level,
  input  wire logic [2:0] blue_level,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            top_red,
  output logic            top_green,
  output logic            top_blue,
  output logic            bottom_red,
  output logic            bottom_green,
  output logic            bottom_blue,
  output logic            latch_row,
  output logic [3:0]      row_address,
  output logic [2:0]      subframe,
  output logic            frame_end
);

  localparam int PW = lmsd_pkg::POS_W;

  logic                clearing;
  lmsd_pkg::addr_t     clr_addr;
  logic                hold;
  logic                in_accept;
  logic                do_write, do_clear, do_scan;
  logic [PW-1:0]       frow, fcol, prow;
  logic                in_range, lower;
  lmsd_pkg::addr_t     waddr, ram_waddr, raddr;
  lmsd_pkg::pixel_t    ram_wdata, top_pixel, bottom_pixel;
  logic                top_wr, bottom_wr;
  lmsd_pkg::scan_pos_t pos;

  assign in_stall  = clearing || hold;
  assign in_accept = in_valid && !in_stall;
  assign do_write  = in_accept && (kind == lmsd_pkg::KIND_WRITE);
  assign do_clear  = in_accept && (kind == lmsd_pkg::KIND_CLEAR);
  assign do_scan   = in_accept && (kind == lmsd_pkg::KIND_SCAN);

  // Fold the view position onto the panel
  always_comb begin
    if (row_in >= 6'(lmsd_pkg::FOLD_ROW)) begin
      frow = PW'(lmsd_pkg::FOLD_ROW_M) - PW'(row_in);
      fcol = PW'(lmsd_pkg::FOLD_COL_M) - PW'(column_in);
    end else begin
      frow = PW'(row_in);
      fcol = PW'(column_in);
    end
    in_range = (frow < PW'(2 * lmsd_pkg::ROW_PAIRS)) &&
               (fcol < PW'(lmsd_pkg::PANEL_WIDTH));
    lower = (frow >= PW'(lmsd_pkg::ROW_PAIRS));
    prow  = lower ? frow - PW'(lmsd_pkg::ROW_PAIRS) : frow;
    waddr = {prow[lmsd_pkg::RP_W-1:0], fcol[lmsd_pkg::COL_W-1:0]};
  end

  assign ram_waddr = clearing ? clr_addr : waddr;
  assign ram_wdata = clearing ? '0 : {blue_level, green_level, red_level};
  assign top_wr    = clearing || (do_write && in_range && !lower);
  assign bottom_wr = clearing || (do_write && in_range && lower);
  assign raddr     = {pos.rp, pos.col};

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (do_clear) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  lmsd_ram u_top_ram (
    .clk     (clk),
    .wr_en   (top_wr),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (do_scan),
    .rd_addr (raddr),
    .rd_data (top_pixel)
  );

  lmsd_ram u_bottom_ram (
    .clk     (clk),
    .wr_en   (bottom_wr),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (do_scan),
    .rd_addr (raddr),
    .rd_data (bottom_pixel)
  );

  lmsd_scan_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (do_scan),
    .pos     (pos)
  );

  lmsd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .issue        (do_scan),
    .issue_pos    (pos),
    .top_pixel    (top_pixel),
    .bottom_pixel (bottom_pixel),
    .hold         (hold),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .top_red      (top_red),
    .top_green    (top_green),
    .top_blue     (top_blue),
    .bottom_red   (bottom_red),
    .bottom_green (bottom_green),
    .bottom_blue  (bottom_blue),
    .latch_row    (latch_row),
    .row_address  (row_address),
    .subframe     (subframe),
    .frame_end    (frame_end)
  );

endmodule
`default_nettype wire

### src/lmsd_checker.sv
// Port-level checks for the LED matrix scan driver, bound to the top level.
// Depends on lmsd_pkg for panel sizes and command codes.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] kind,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       latch_row,
  input wire logic [3:0] row_address,
  input wire logic [2:0] subframe,
  input wire logic       frame_end
);

  // hold a stalled transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  // frame end only on the last column of the last row pair and subframe
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> latch_row &&
      row_address == 4'(lmsd_pkg::ROW_PAIRS - 1) &&
      subframe == 3'(lmsd_pkg::SUBFRAMES - 1))
    else $error("frame end away from the last shift of a frame");

  // reset starts the clearing pass
  assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken right after reset");

  // a clear starts the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == lmsd_pkg::KIND_CLEAR |=> in_stall)
    else $error("input taken right after a clear");

endmodule

bind led_matrix_scan_driver lmsd_checker u_lmsd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .latch_row   (latch_row),
  .row_address (row_address),
  .subframe    (subframe),
  .frame_end   (frame_end)
);
`default_nettype wire

### sim/tb_led_matrix_scan_driver.sv
// Self-checking testbench for led_matrix_scan_driver: pixel writes, clears and scan ticks
// go through a scoreboard that models the store and the scan counters and checks every shift.
// Depends on lmsd_pkg and the led_matrix_scan_driver RTL.
`timescale 1ns / 1ps
module tb_led_matrix_scan_driver;
  import lmsd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MIXED_COMMANDS = 1600;
  localparam int STORE_ENTRIES = 2 * ROW_PAIRS * PANEL_WIDTH;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic [2:0] red;
    logic [2:0] green;
    logic [2:0] blue;
  } command_t;

  typedef struct packed {
    logic       top_red;
    logic       top_green;
    logic       top_blue;
    logic       bottom_red;
    logic       bottom_green;
    logic       bottom_blue;
    logic       latch_row;
    logic [3:0] row_address;
    logic [2:0] subframe;
    logic       frame_end;
  } panel_shift_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  class panel_shift_scoreboard;
    logic [8:0] pixels [0:STORE_ENTRIES-1];
    int unsigned col_pos, pair_pos, sub_pos;
    panel_shift_t expected_shifts[$];
    int unsigned mismatches, shifts_checked, frames_seen, clears_seen;

    function new();
      wipe_pixels();
      col_pos = 0;
      pair_pos = 0;
      sub_pos = 0;
      mismatches = 0;
      shifts_checked = 0;
      frames_seen = 0;
      clears_seen = 0;
    endfunction

    function void wipe_pixels();
      foreach (pixels[i]) pixels[i] = '0;
    endfunction

    function logic level_shows(logic [2:0] level, int unsigned k);
      return (level != 3'd0) && (k <= level);
    endfunction

    function int unsigned pending();
      return expected_shifts.size();
    endfunction

    function void note_command(command_t c);
      int unsigned row, col;
      logic [8:0] top, bot;
      panel_shift_t s;
      case (c.kind)
        KIND_WRITE: begin
          row = c.row;
          col = c.col;
          if (row >= FOLD_ROW) begin
            row = FOLD_ROW_M - row;
            col = FOLD_COL_M - col;
          end
          if (row < 2 * ROW_PAIRS && col < PANEL_WIDTH)
            pixels[row * PANEL_WIDTH + col] = {c.blue, c.green, c.red};
        end
        KIND_CLEAR: begin
          wipe_pixels();
          clears_seen++;
        end
        KIND_SCAN: begin
          top = pixels[pair_pos * PANEL_WIDTH + col_pos];
          bot = pixels[(pair_pos + ROW_PAIRS) * PANEL_WIDTH + col_pos];
          s.top_red      = level_shows(top[2:0], sub_pos);
          s.top_green    = level_shows(top[5:3], sub_pos);
          s.top_blue     = level_shows(top[8:6], sub_pos);
          s.bottom_red   = level_shows(bot[2:0], sub_pos);
          s.bottom_green = level_shows(bot[5:3], sub_pos);
          s.bottom_blue  = level_shows(bot[8:6], sub_pos);
          s.latch_row    = (col_pos == PANEL_WIDTH - 1);
          s.row_address  = 4'(pair_pos);
          s.subframe     = 3'(sub_pos);
          s.frame_end    = s.latch_row && (pair_pos == ROW_PAIRS - 1) &&
                           (sub_pos == SUBFRAMES - 1);
          if (s.frame_end) frames_seen++;
          if (s.latch_row) begin
            col_pos = 0;
            if (pair_pos == ROW_PAIRS - 1) begin
              pair_pos = 0;
              sub_pos = (sub_pos == SUBFRAMES - 1) ? 0 : sub_pos + 1;
            end else begin
              pair_pos++;
            end
          end else begin
            col_pos++;
          end
          expected_shifts.push_back(s);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 30) $display("MISMATCH shift %0d: %s", shifts_checked, msg);
      mismatches++;
    endtask

    task check_shift(panel_shift_t got);
      panel_shift_t exp;
      if (expected_shifts.size() == 0) begin
        report_mismatch("shift with nothing expected");
        return;
      end
      exp = expected_shifts.pop_front();
      if (got.top_red !== exp.top_red)
        report_mismatch($sformatf("top_red %0b, expected %0b", got.top_red, exp.top_red));
      if (got.top_green !== exp.top_green)
        report_mismatch($sformatf("top_green %0b, expected %0b", got.top_green, exp.top_green));
      if (got.top_blue !== exp.top_blue)
        report_mismatch($sformatf("top_blue %0b, expected %0b", got.top_blue, exp.top_blue));
      if (got.bottom_red !== exp.bottom_red)
        report_mismatch($sformatf("bottom_red %0b, expected %0b",
                                  got.bottom_red, exp.bottom_red));
      if (got.bottom_green !== exp.bottom_green)
        report_mismatch($sformatf("bottom_green %0b, expected %0b",
                                  got.bottom_green, exp.bottom_green));
      if (got.bottom_blue !== exp.bottom_blue)
        report_mismatch($sformatf("bottom_blue %0b, expected %0b",
                                  got.bottom_blue, exp.bottom_blue));
      if (got.latch_row !== exp.latch_row)
        report_mismatch($sformatf("latch_row %0b, expected %0b", got.latch_row, exp.latch_row));
      if (got.row_address !== exp.row_address)
        report_mismatch($sformatf("row_address %0d, expected %0d",
                                  got.row_address, exp.row_address));
      if (got.subframe !== exp.subframe)
        report_mismatch($sformatf("subframe %0d, expected %0d", got.subframe, exp.subframe));
      if (got.frame_end !== exp.frame_end)
        report_mismatch($sformatf("frame_end %0b, expected %0b", got.frame_end, exp.frame_end));
      shifts_checked++;
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] kind = KIND_WRITE;
  logic [5:0] row_in = '0;
  logic [5:0] column_in = '0;
  logic [2:0] red_level = '0;
  logic [2:0] green_level = '0;
  logic [2:0] blue_level = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       top_red, top_green, top_blue;
  logic       bottom_red, bottom_green, bottom_blue;
  logic       latch_row;
  logic [3:0] row_address;
  logic [2:0] subframe;
  logic       frame_end;

  panel_shift_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned commands_sent = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  led_matrix_scan_driver dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .row_in       (row_in),
    .column_in    (column_in),
    .red_level    (red_level),
    .green_level  (green_level),
    .blue_level   (blue_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .top_red      (top_red),
    .top_green    (top_green),
    .top_blue     (top_blue),
    .bottom_red   (bottom_red),
    .bottom_green (bottom_green),
    .bottom_blue  (bottom_blue),
    .latch_row    (latch_row),
    .row_address  (row_address),
    .subframe     (subframe),
    .frame_end    (frame_end)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d shifts outstanding", cycle_count, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_shift({top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue,
                        latch_row, row_address, subframe, frame_end});
      if (in_valid && !in_stall)
        sb.note_command({kind, row_in, column_in, red_level, green_level, blue_level});
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_left <= $urandom_range(20, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_SPARSE:   out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= (stall_left[1:0] == 2'd0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  task automatic send_command(command_t c);
    @(negedge clk);
    in_valid    <= 1'b1;
    kind        <= c.kind;
    row_in      <= c.row;
    column_in   <= c.col;
    red_level   <= c.red;
    green_level <= c.green;
    blue_level  <= c.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    commands_sent++;
  endtask

  task automatic hold_off(int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  function automatic command_t pixel_write(int unsigned r, int unsigned c,
                                           int unsigned red, int unsigned green,
                                           int unsigned blue);
    return {KIND_WRITE, 6'(r), 6'(c), 3'(red), 3'(green), 3'(blue)};
  endfunction

  function automatic logic [2:0] random_level();
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 3'd0;
    if (pick == 1) return 3'd7;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic command_t random_command(int unsigned write_pct, int unsigned unused_pct,
                                              int unsigned clear_pct);
    command_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.row   = 6'($urandom_range(0, 63));
    c.col   = 6'($urandom_range(0, 63));
    c.red   = random_level();
    c.green = random_level();
    c.blue  = random_level();
    if (pick < write_pct) c.kind = KIND_WRITE;
    else if (pick < write_pct + unused_pct) c.kind = KIND_UNUSED;
    else if (pick < write_pct + unused_pct + clear_pct) c.kind = KIND_CLEAR;
    else c.kind = KIND_SCAN;
    return c;
  endfunction

  task automatic random_burst(int unsigned write_pct, int unsigned unused_pct,
                              int unsigned clear_pct, ref int unsigned counted);
    command_t c;
    int unsigned burst;
    burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    repeat (burst) begin
      c = random_command(write_pct, unused_pct, clear_pct);
      send_command(c);
      if (c.kind != KIND_UNUSED) counted++;
    end
    hold_off(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
  endtask

  initial begin
    command_t directed[$];
    int unsigned counted;
    counted = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // scan an empty store, then exercise fold corners, level extremes, an unused kind, a clear and live reads
    directed.push_back({KIND_SCAN, 6'd0, 6'd0, 3'd0, 3'd0, 3'd0});
    directed.push_back(pixel_write(0, 0, 7, 7, 7));
    directed.push_back(pixel_write(16, 0, 1, 2, 3));
    directed.push_back({KIND_SCAN, 6'd63, 6'd63, 3'd7, 3'd7, 3'd7});
    directed.push_back(pixel_write(0, 1, 0, 0, 0));
    directed.push_back(pixel_write(16, 1, 7, 0, 5));
    directed.push_back(pixel_write(47, 63, 7, 0, 5));
    directed.push_back(pixel_write(63, 63, 4, 4, 4));
    directed.push_back(pixel_write(32, 0, 7, 7, 7));
    directed.push_back(pixel_write(31, 63, 6, 5, 4));
    directed.push_back(pixel_write(63, 0, 1, 1, 1));
    directed.push_back({KIND_SCAN, 6'd0, 6'd0, 3'd0, 3'd0, 3'd0});
    directed.push_back({KIND_UNUSED, 6'd63, 6'd63, 3'd7, 3'd7, 3'd7});
    directed.push_back(pixel_write(0, 2, 7, 7, 7));
    directed.push_back(pixel_write(16, 2, 7, 7, 7));
    directed.push_back({KIND_CLEAR, 6'd0, 6'd0, 3'd0, 3'd0, 3'd0});
    directed.push_back({KIND_SCAN, 6'd0, 6'd0, 3'd0, 3'd0, 3'd0});
    directed.push_back(pixel_write(0, 3, 3, 0, 7));
    directed.push_back(pixel_write(16, 3, 0, 7, 1));
    directed.push_back({KIND_SCAN, 6'd0, 6'd0, 3'd0, 3'd0, 3'd0});
    foreach (directed[i]) send_command(directed[i]);
    hold_off(3);

    while (counted < MIXED_COMMANDS) random_burst(40, 2, 1, counted);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d transactions (%0d clears), checked %0d shifts over %0d full frame(s)",
             commands_sent, sb.clears_seen, sb.shifts_checked, sb.frames_seen);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### led_matrix_scan_driver.f
src/lmsd_pkg.sv
src/lmsd_ram.sv
src/lmsd_scan_seq.sv
src/lmsd_out_stage.sv
src/led_matrix_scan_driver.sv
src/lmsd_checker.sv
sim/tb_led_matrix_scan_driver.sv
